[rtl/hpa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpa_pkg
// shared types and constants of the handle pool allocator
// ----------------------------------------------------------------------------
package hpa_pkg;

    localparam int HANDLE_W = 10;
    localparam int STRIDE_W = 13;
    localparam int OFFSET_W = 22;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd1;

    typedef enum logic [1:0] {
        REQ_ALLOC      = 2'd0,
        REQ_FREE       = 2'd1,
        REQ_LOOKUP     = 2'd2,
        REQ_RAW_LOOKUP = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        STS_OK   = 2'd0,
        STS_FULL = 2'd1,
        STS_BAD  = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic commit;
    } t_hpa_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_hpa_sts;

endpackage
`default_nettype wire

[rtl/handle_pool_allocator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// handle_pool_allocator_top
// slot allocator with a free stack, validity bitmap and offset lookup
// ----------------------------------------------------------------------------
// On acceptance of a request the slot bitmap and the free stack top are read;
// then, once the result register is free, bitmap, stack and counters are
// committed and the result register is loaded. A new request is accepted only
// after the last one has committed. A held result stalls the commit. The
// bitmap needs no clearing pass: every handle check is bounded by the
// high-water extent, below which all entries have been written since reset.
// Stride writes are taken at any time, ready is always high.
module handle_pool_allocator_top #(
    parameter int POOL_SLOTS = 1024
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [1:0]                      i_req_type,
    input  wire logic signed [hpa_pkg::HANDLE_W:0] i_slot_handle,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [1:0]                           o_status,
    output logic [hpa_pkg::HANDLE_W-1:0]         o_granted_handle,
    output logic [hpa_pkg::OFFSET_W-1:0]         o_byte_offset,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [hpa_pkg::STRIDE_W-1:0]    i_cfg_data
);
    import hpa_pkg::*;

    t_hpa_cmd w_cmd;
    t_hpa_sts w_sts;

    assign o_cfg_ready = 1'b1;

    hpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    hpa_datapath #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_req_type       (i_req_type),
        .i_slot_handle    (i_slot_handle),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_granted_handle (o_granted_handle),
        .o_byte_offset    (o_byte_offset)
    );

endmodule
`default_nettype wire

[rtl/hpa_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpa_datapath
// slot bitmap, free stack, counters, offset multiplier and result register
// ----------------------------------------------------------------------------
module hpa_datapath #(
    parameter int POOL_SLOTS = 1024
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire hpa_pkg::t_hpa_cmd                   i_cmd,
    output hpa_pkg::t_hpa_sts                        o_sts,
    input  wire logic [1:0]                          i_req_type,
    input  wire logic [hpa_pkg::HANDLE_W:0]          i_slot_handle,
    input  wire logic                                i_cfg_valid,
    input  wire logic [hpa_pkg::STRIDE_W-1:0]        i_cfg_data,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic [1:0]                               o_status,
    output logic [hpa_pkg::HANDLE_W-1:0]             o_granted_handle,
    output logic [hpa_pkg::OFFSET_W-1:0]             o_byte_offset
);
    import hpa_pkg::*;

    localparam int AW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CW = $clog2(POOL_SLOTS + 1);
    localparam int EW = (CW > HANDLE_W + 1) ? CW : HANDLE_W + 1;
    localparam int PROD_W = HANDLE_W + STRIDE_W;
    localparam logic [EW-1:0] SLOTS_E = EW'(POOL_SLOTS);

    // storage
    logic                r_valid_mem [POOL_SLOTS];
    logic [AW-1:0]       r_stack_mem [POOL_SLOTS];

    logic [STRIDE_W-1:0] r_stride;
    t_req                r_req;
    logic [HANDLE_W:0]   r_handle;
    logic                r_valid_rd;
    logic [AW-1:0]       r_stack_rd;
    logic [CW-1:0]       r_live, n_live;
    logic [CW-1:0]       r_freed, n_freed;
    logic [CW-1:0]       r_hw, n_hw;
    logic                r_out_valid;
    t_status             r_status, n_status;
    logic [HANDLE_W-1:0] r_granted, n_granted;
    logic [OFFSET_W-1:0] r_offset, n_offset;

    logic [EW-1:0]       w_in_slot_e;
    logic [CW-1:0]       w_freed_dec;
    logic [HANDLE_W-1:0] w_slot;
    logic [EW-1:0]       w_slot_e;
    logic [EW-1:0]       w_slot_inc;
    logic                w_present;
    logic                w_live_ok;
    logic                w_pop;
    logic [EW-1:0]       w_alloc_idx;
    logic [EW-1:0]       w_idx_inc;
    logic [PROD_W-1:0]   w_prod;

    logic                w_vwr_en;
    logic [AW-1:0]       w_vwr_addr;
    logic                w_vwr_data;
    logic                w_swr_en;

    // read addresses come straight from the request and the stack top
    assign w_in_slot_e = EW'(i_slot_handle[HANDLE_W-1:0]);
    assign w_freed_dec = r_freed - CW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req      <= t_req'(i_req_type);
            r_handle   <= i_slot_handle;
            r_valid_rd <= r_valid_mem[w_in_slot_e[AW-1:0]];
            r_stack_rd <= r_stack_mem[w_freed_dec[AW-1:0]];
        end
    end

    assign w_slot     = r_handle[HANDLE_W-1:0];
    assign w_slot_e   = EW'(w_slot);
    assign w_slot_inc = w_slot_e + EW'(1);
    assign w_present  = !r_handle[HANDLE_W];
    // bounded by high water, so only bitmap entries written since reset are used
    assign w_live_ok  = w_present && (w_slot_e < EW'(r_hw)) && (w_slot_e < SLOTS_E)
                        && r_valid_rd;
    assign w_pop      = (r_freed != '0) && (EW'(r_freed) <= SLOTS_E);
    assign w_alloc_idx = w_pop ? EW'(r_stack_rd) : EW'(r_live);
    assign w_idx_inc  = w_alloc_idx + EW'(1);
    assign w_prod     = PROD_W'(w_slot) * PROD_W'(r_stride);

    always_comb begin
        n_live     = r_live;
        n_freed    = r_freed;
        n_hw       = r_hw;
        n_status   = STS_BAD;
        n_granted  = '0;
        n_offset   = '0;
        w_vwr_en   = 1'b0;
        w_vwr_addr = w_slot_e[AW-1:0];
        w_vwr_data = 1'b0;
        w_swr_en   = 1'b0;
        unique case (r_req)
            REQ_ALLOC: begin
                if (EW'(r_live) >= SLOTS_E) begin
                    n_status = STS_FULL;
                end else if (w_alloc_idx < SLOTS_E) begin
                    if (w_pop) begin
                        n_freed = w_freed_dec;
                    end
                    w_vwr_en   = 1'b1;
                    w_vwr_addr = w_alloc_idx[AW-1:0];
                    w_vwr_data = 1'b1;
                    n_live     = r_live + CW'(1);
                    if (w_alloc_idx >= EW'(r_hw)) begin
                        n_hw = w_idx_inc[CW-1:0];
                    end
                    n_status  = STS_OK;
                    n_granted = w_alloc_idx[HANDLE_W-1:0];
                end else begin
                    n_status = STS_FULL;
                end
            end
            REQ_FREE: begin
                if (w_live_ok && (EW'(r_freed) < SLOTS_E)) begin
                    w_vwr_en = 1'b1;
                    w_swr_en = 1'b1;
                    n_freed  = r_freed + CW'(1);
                    if (r_live != '0) begin
                        n_live = r_live - CW'(1);
                    end
                    // top slot released: extent shrinks by one
                    if (w_slot_inc == EW'(r_hw)) begin
                        n_hw = r_hw - CW'(1);
                    end
                    n_status = STS_OK;
                end
            end
            REQ_LOOKUP: begin
                if (w_live_ok) begin
                    n_status = STS_OK;
                    n_offset = w_prod[OFFSET_W-1:0];
                end
            end
            REQ_RAW_LOOKUP: begin
                if (w_present) begin
                    n_status = STS_OK;
                    n_offset = w_prod[OFFSET_W-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_vwr_en) begin
            r_valid_mem[w_vwr_addr] <= w_vwr_data;
        end
        if (i_cmd.commit && w_swr_en) begin
            r_stack_mem[r_freed[AW-1:0]] <= w_slot_e[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride    <= STRIDE_RESET;
            r_live      <= '0;
            r_freed     <= '0;
            r_hw        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_stride <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_live      <= n_live;
                r_freed     <= n_freed;
                r_hw        <= n_hw;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status  <= n_status;
            r_granted <= n_granted;
            r_offset  <= n_offset;
        end
    end

    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_granted_handle = r_granted;
    assign o_byte_offset    = r_offset;

endmodule
`default_nettype wire

[rtl/hpa_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpa_ctrl
// request sequencer: latch and read, then commit into the result register
// ----------------------------------------------------------------------------
module hpa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire hpa_pkg::t_hpa_sts i_sts,
    output hpa_pkg::t_hpa_cmd      o_cmd
);
    import hpa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the result register can take the transaction
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire
